>>> design/accel_tilt_angle_macros.svh
// assertion macros for the accel_tilt_angle block
// used by accel_tilt_angle.sv; expects signals named clock and reset in scope
`ifndef ACCEL_TILT_ANGLE_MACROS_SVH
`define ACCEL_TILT_ANGLE_MACROS_SVH

// condition implies consequence in the same cycle
`define ATA_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("accel_tilt_angle: same-cycle check failed");

// condition implies consequence in the next cycle
`define ATA_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("accel_tilt_angle: next-cycle check failed");

`endif

>>> design/ata_pkg.sv
// types and constants for the accel_tilt_angle block
// no dependencies; used by accel_tilt_angle.sv
`default_nettype none

package ata_pkg;

   // cordic datapath widths
   localparam int XW = 28;          // x/y: reading * 256 plus cordic growth
   localparam int ZW = 26;          // angle accumulator, 1/65536 degree
   localparam int PW = 29;          // angle times gain
   localparam int TABLE_LEN = 24;

   typedef logic signed [15:0] reading_type;
   typedef logic signed [XW-1:0] xval_type;
   typedef logic signed [ZW-1:0] zval_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [17:0] angle_type;

   typedef struct packed {
      reading_type ax;
      reading_type ay;
      reading_type az;
   } readings_type;

   typedef struct packed {
      xval_type x;
      xval_type y;
      zval_type z;
      logic zero;
      readings_type rd;
   } cordic_stage_type;

   // atan(2^-i) in 1/65536 degree
   localparam zval_type ATAN_TABLE [TABLE_LEN] = '{
      zval_type'(2949120), zval_type'(1740967), zval_type'(919879), zval_type'(466945),
      zval_type'(234379), zval_type'(117304), zval_type'(58666), zval_type'(29335),
      zval_type'(14668), zval_type'(7334), zval_type'(3667), zval_type'(1833),
      zval_type'(917), zval_type'(458), zval_type'(229), zval_type'(115),
      zval_type'(57), zval_type'(29), zval_type'(14), zval_type'(7),
      zval_type'(4), zval_type'(2), zval_type'(1), zval_type'(0)
   };

   localparam zval_type ANGLE_90 = zval_type'(5898240);
   localparam zval_type ROUND_Z = zval_type'(128);
   localparam zval_type RAW_MAX = zval_type'(46080);
   localparam zval_type RAW_MIN = zval_type'(-46080);
   localparam prod_type ROUND_P = prod_type'(128);
   localparam prod_type OUT_MAX = prod_type'(69120);
   localparam prod_type OUT_MIN = prod_type'(-69120);
   localparam angle_type TILT_MAX = angle_type'(69120);
   localparam angle_type TILT_MIN = angle_type'(-69120);

   // register index (byte address / 4)
   localparam logic REG_ANGLE_OFFSET = 1'b0;
   localparam logic REG_ANGLE_GAIN = 1'b1;

   localparam logic [15:0] OFFSET_RESET = 16'd2324;
   localparam logic [9:0] GAIN_RESET = 10'd384;

endpackage

`default_nettype wire

>>> design/accel_tilt_angle.sv
// Accelerometer tilt: joins six raw bytes into signed X/Y/Z readings, gives the
// remapped vector (Y, -X, -Z) and the tilt angle atan2(X, Z) in 1/256 degree from a
// pipelined vectoring CORDIC, with offset on positive angles, gain and saturation.
// Takes one request per cycle unless req_stall is high. The pipeline has
// one entry stage with the half-plane turn, one stage per CORDIC iteration (capped at
// 24), then round/clamp, offset, gain multiply and output rounding stages. Every stage
// holds on its own, so bubbles close up when the output is stalled. Registers:
// angle_offset at address 0, angle_gain at address 4.
// Depends on ata_pkg.sv and accel_tilt_angle_macros.svh.
`default_nettype none
`include "accel_tilt_angle_macros.svh"

module accel_tilt_angle #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   // request channel
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [7:0] req_x_low,
   input  wire logic [7:0] req_x_high,
   input  wire logic [7:0] req_y_low,
   input  wire logic [7:0] req_y_high,
   input  wire logic [7:0] req_z_low,
   input  wire logic [7:0] req_z_high,
   // result channel
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [15:0] rsp_accel_x,
   output logic signed [15:0] rsp_accel_y,
   output logic signed [15:0] rsp_accel_z,
   output logic signed [15:0] rsp_vec_first,
   output logic signed [16:0] rsp_vec_second,
   output logic signed [16:0] rsp_vec_third,
   output logic signed [17:0] rsp_tilt_angle,
   // configuration
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [2:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   localparam int STEPS = (CORDIC_STEPS > ata_pkg::TABLE_LEN) ?
                          ata_pkg::TABLE_LEN : CORDIC_STEPS;

   // ---------------- configuration registers
   logic [15:0] offset_ff, offset_in;
   logic [9:0] gain_ff, gain_in;
   logic cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      offset_in = offset_ff;
      gain_in = gain_ff;
      if (cfg_wr) begin
         case (paddr[2])
            ata_pkg::REG_ANGLE_OFFSET: offset_in = pwdata[15:0];
            ata_pkg::REG_ANGLE_GAIN: gain_in = pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         ata_pkg::REG_ANGLE_OFFSET: prdata = {16'd0, offset_ff};
         ata_pkg::REG_ANGLE_GAIN: prdata = {22'd0, gain_ff};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= ata_pkg::OFFSET_RESET;
         gain_ff <= ata_pkg::GAIN_RESET;
      end else begin
         offset_ff <= offset_in;
         gain_ff <= gain_in;
      end
   end

   // ---------------- pipeline control
   logic [STEPS:0] cv_ff, cv_in, cr;
   ata_pkg::cordic_stage_type stage_ff [STEPS+1];
   ata_pkg::cordic_stage_type stage_in [STEPS+1];

   logic p1_v_ff, p1_v_in, p2_v_ff, p2_v_in, p3_v_ff, p3_v_in, rsp_valid_ff, rsp_valid_in;
   logic rdy_p1, rdy_p2, rdy_p3, rdy_out;

   // a stage takes new data when it is empty or its successor moves
   assign rdy_out = !rsp_valid_ff || !rsp_stall;
   assign rdy_p3 = !p3_v_ff || rdy_out;
   assign rdy_p2 = !p2_v_ff || rdy_p3;
   assign rdy_p1 = !p1_v_ff || rdy_p2;
   assign cr[STEPS] = !cv_ff[STEPS] || rdy_p1;

   for (genvar k = 0; k < STEPS; k++) begin : g_ready
      assign cr[k] = !cv_ff[k] || cr[k+1];
   end

   assign req_stall = !cr[0];

   assign cv_in[0] = cr[0] ? req_valid : cv_ff[0];
   for (genvar k = 1; k <= STEPS; k++) begin : g_valid
      assign cv_in[k] = cr[k] ? cv_ff[k-1] : cv_ff[k];
   end

   // ---------------- entry stage: assemble readings, turn into right half plane
   ata_pkg::cordic_stage_type entry;
   ata_pkg::xval_type px, py;

   always_comb begin
      entry.rd.ax = ata_pkg::reading_type'({req_x_high, req_x_low});
      entry.rd.ay = ata_pkg::reading_type'({req_y_high, req_y_low});
      entry.rd.az = ata_pkg::reading_type'({req_z_high, req_z_low});
      px = ata_pkg::xval_type'(entry.rd.az) <<< 8;
      py = ata_pkg::xval_type'(entry.rd.ax) <<< 8;
      entry.zero = (entry.rd.ax == 16'sd0) && (entry.rd.az == 16'sd0);
      entry.x = px;
      entry.y = py;
      entry.z = '0;
      if (px < 0) begin
         if (py >= 0) begin
            entry.x = py;
            entry.y = -px;
            entry.z = ata_pkg::ANGLE_90;
         end else begin
            entry.x = -py;
            entry.y = px;
            entry.z = -ata_pkg::ANGLE_90;
         end
      end
      stage_in[0] = cr[0] ? entry : stage_ff[0];
   end

   // ---------------- cordic iterations, one per stage
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      ata_pkg::cordic_stage_type nxt;
      always_comb begin
         nxt = stage_ff[k-1];
         if (stage_ff[k-1].y >= 0) begin
            nxt.x = stage_ff[k-1].x + (stage_ff[k-1].y >>> (k-1));
            nxt.y = stage_ff[k-1].y - (stage_ff[k-1].x >>> (k-1));
            nxt.z = stage_ff[k-1].z + ata_pkg::ATAN_TABLE[k-1];
         end else begin
            nxt.x = stage_ff[k-1].x - (stage_ff[k-1].y >>> (k-1));
            nxt.y = stage_ff[k-1].y + (stage_ff[k-1].x >>> (k-1));
            nxt.z = stage_ff[k-1].z - ata_pkg::ATAN_TABLE[k-1];
         end
         stage_in[k] = cr[k] ? nxt : stage_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   // ---------------- post stages
   ata_pkg::readings_type p1_rd_ff, p1_rd_in, p2_rd_ff, p2_rd_in, p3_rd_ff, p3_rd_in;
   ata_pkg::angle_type p1_raw_ff, p1_raw_in, p2_corr_ff, p2_corr_in;
   ata_pkg::prod_type p3_prod_ff, p3_prod_in;
   ata_pkg::zval_type zrnd;
   ata_pkg::prod_type prnd, prod_full;
   logic signed [18:0] corr_wide;

   logic signed [15:0] rsp_accel_x_ff, rsp_accel_x_in, rsp_accel_y_ff, rsp_accel_y_in;
   logic signed [15:0] rsp_accel_z_ff, rsp_accel_z_in;
   logic signed [16:0] rsp_vec_second_ff, rsp_vec_second_in;
   logic signed [16:0] rsp_vec_third_ff, rsp_vec_third_in;
   ata_pkg::angle_type rsp_tilt_ff, rsp_tilt_in;

   // round accumulator to 1/256 degree and clamp to half a turn
   always_comb begin
      zrnd = (stage_ff[STEPS].z + ata_pkg::ROUND_Z) >>> 8;
      if (zrnd > ata_pkg::RAW_MAX) begin
         zrnd = ata_pkg::RAW_MAX;
      end else if (zrnd < ata_pkg::RAW_MIN) begin
         zrnd = ata_pkg::RAW_MIN;
      end
      if (stage_ff[STEPS].zero) begin
         zrnd = '0;
      end
      p1_v_in = rdy_p1 ? cv_ff[STEPS] : p1_v_ff;
      p1_raw_in = rdy_p1 ? ata_pkg::angle_type'(zrnd) : p1_raw_ff;
      p1_rd_in = rdy_p1 ? stage_ff[STEPS].rd : p1_rd_ff;
   end

   // offset only on positive angles
   always_comb begin
      corr_wide = 19'(p1_raw_ff);
      if (p1_raw_ff > 0) begin
         corr_wide = 19'(p1_raw_ff) - $signed({3'd0, offset_ff});
      end
      p2_v_in = rdy_p2 ? p1_v_ff : p2_v_ff;
      p2_corr_in = rdy_p2 ? ata_pkg::angle_type'(corr_wide) : p2_corr_ff;
      p2_rd_in = rdy_p2 ? p1_rd_ff : p2_rd_ff;
   end

   always_comb begin
      prod_full = ata_pkg::prod_type'(p2_corr_ff) *
                  ata_pkg::prod_type'($signed({1'b0, gain_ff}));
      p3_v_in = rdy_p3 ? p2_v_ff : p3_v_ff;
      p3_prod_in = rdy_p3 ? prod_full : p3_prod_ff;
      p3_rd_in = rdy_p3 ? p2_rd_ff : p3_rd_ff;
   end

   always_comb begin
      prnd = (p3_prod_ff + ata_pkg::ROUND_P) >>> 8;
      if (prnd > ata_pkg::OUT_MAX) begin
         prnd = ata_pkg::OUT_MAX;
      end else if (prnd < ata_pkg::OUT_MIN) begin
         prnd = ata_pkg::OUT_MIN;
      end
      rsp_valid_in = rdy_out ? p3_v_ff : rsp_valid_ff;
      rsp_tilt_in = rdy_out ? ata_pkg::angle_type'(prnd) : rsp_tilt_ff;
      rsp_accel_x_in = rdy_out ? p3_rd_ff.ax : rsp_accel_x_ff;
      rsp_accel_y_in = rdy_out ? p3_rd_ff.ay : rsp_accel_y_ff;
      rsp_accel_z_in = rdy_out ? p3_rd_ff.az : rsp_accel_z_ff;
      rsp_vec_second_in = rdy_out ? -17'(p3_rd_ff.ax) : rsp_vec_second_ff;
      rsp_vec_third_in = rdy_out ? -17'(p3_rd_ff.az) : rsp_vec_third_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cv_ff <= cv_in;
         p1_v_ff <= p1_v_in;
         p2_v_ff <= p2_v_in;
         p3_v_ff <= p3_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_raw_ff <= p1_raw_in;
      p1_rd_ff <= p1_rd_in;
      p2_corr_ff <= p2_corr_in;
      p2_rd_ff <= p2_rd_in;
      p3_prod_ff <= p3_prod_in;
      p3_rd_ff <= p3_rd_in;
      rsp_tilt_ff <= rsp_tilt_in;
      rsp_accel_x_ff <= rsp_accel_x_in;
      rsp_accel_y_ff <= rsp_accel_y_in;
      rsp_accel_z_ff <= rsp_accel_z_in;
      rsp_vec_second_ff <= rsp_vec_second_in;
      rsp_vec_third_ff <= rsp_vec_third_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_accel_x = rsp_accel_x_ff;
   assign rsp_accel_y = rsp_accel_y_ff;
   assign rsp_accel_z = rsp_accel_z_ff;
   assign rsp_vec_first = rsp_accel_y_ff;
   assign rsp_vec_second = rsp_vec_second_ff;
   assign rsp_vec_third = rsp_vec_third_ff;
   assign rsp_tilt_angle = rsp_tilt_ff;

   // ---------------- assertions
   logic tilt_ok;
   assign tilt_ok = (rsp_tilt_ff <= ata_pkg::TILT_MAX) && (rsp_tilt_ff >= ata_pkg::TILT_MIN);

   // input only backs up when the entry stage is full and the output is held
   `ATA_ASSERT_SAME(a_stall_source, req_stall, cv_ff[0] && rsp_valid_ff && rsp_stall)
   // a taken result with nothing behind it leaves the output empty
   `ATA_ASSERT_NEXT(a_no_repeat, rsp_valid_ff && !rsp_stall && !p3_v_ff, !rsp_valid_ff)
   // zero vector gives a zero raw angle
   `ATA_ASSERT_NEXT(a_zero_raw, rdy_p1 && cv_ff[STEPS] && stage_ff[STEPS].zero, p1_raw_ff == 0)
   `ATA_ASSERT_SAME(a_tilt_range, rsp_valid_ff, tilt_ok)

endmodule

`default_nettype wire

>>> test/accel_tilt_angle_tb.sv
// self-checking testbench for accel_tilt_angle: directed probe table, then random samples
// checked against an in-bench cordic tilt predictor; needs ata_pkg and the accel_tilt_angle rtl
`timescale 1ns / 100ps

module accel_tilt_angle_tb;

   localparam int TILT_STEPS = 16;
   localparam int PIPE_DRAIN = TILT_STEPS + 5 + 10;
   localparam int PHASES = 8;
   localparam int PHASE_REQUESTS = 170;
   localparam int REPORT_LIMIT = 10;

   localparam longint RIGHT_ANGLE = 64'sd5898240;
   localparam longint RAW_BOUND = 64'sd46080;
   localparam longint TILT_BOUND = 64'sd69120;

   // atan(2^-i) in 1/65536 degree
   localparam longint ATAN_STEP [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic [7:0] xl, xh, yl, yh, zl, zh;
   } raw_sample_type;

   typedef struct packed {
      logic signed [15:0] ax, ay, az, vf;
      logic signed [16:0] vs, vt;
      logic signed [17:0] tilt;
   } tilt_result_type;

   typedef struct packed {
      logic [15:0] x, y, z;
      logic typed;
      tilt_result_type want;
   } probe_row_type;

   localparam probe_row_type PROBES [22] = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 17'sh00000, 17'sh00000, 18'sh00000}},
      '{16'h0000, 16'h8000, 16'h0000, 1'b1,
        '{16'sh0000, 16'sh8000, 16'sh0000, 16'sh8000, 17'sh00000, 17'sh00000, 18'sh00000}},
      '{16'h7fff, 16'h7fff, 16'h7fff, 1'b0, '0},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
      '{16'h0000, 16'h1234, 16'hffff, 1'b0, '0},   // straight back, +180
      '{16'hffff, 16'h0001, 16'hffff, 1'b0, '0},
      '{16'h0001, 16'hfffe, 16'hffff, 1'b0, '0},
      '{16'h0000, 16'h00ff, 16'h0001, 1'b0, '0},
      '{16'h0001, 16'hff00, 16'h0000, 1'b0, '0},
      '{16'hffff, 16'h5555, 16'h0000, 1'b0, '0},
      '{16'h7fff, 16'haaaa, 16'h8000, 1'b0, '0},
      '{16'h8000, 16'h3333, 16'h8000, 1'b0, '0},
      '{16'h8000, 16'hcccc, 16'h7fff, 1'b0, '0},
      '{16'h7fff, 16'h0f0f, 16'h7fff, 1'b0, '0},
      '{16'h0100, 16'hf0f0, 16'h0100, 1'b0, '0},
      '{16'h00ff, 16'hff00, 16'hff01, 1'b0, '0},
      '{16'h5555, 16'haaaa, 16'h3333, 1'b0, '0},
      '{16'haaaa, 16'h0101, 16'hcccc, 1'b0, '0},
      '{16'h0064, 16'hfefe, 16'hfed4, 1'b0, '0},
      '{16'hff9c, 16'h7f80, 16'h012c, 1'b0, '0},
      '{16'h0040, 16'h0001, 16'h0800, 1'b0, '0},   // small positive angle, below offset
      '{16'h8000, 16'h0000, 16'h0000, 1'b0, '0}
   };

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_x_low, req_x_high, req_y_low, req_y_high, req_z_low, req_z_high;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_accel_x, rsp_accel_y, rsp_accel_z, rsp_vec_first;
   logic signed [16:0] rsp_vec_second, rsp_vec_third;
   logic signed [17:0] rsp_tilt_angle;
   logic psel, penable, pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   logic [15:0] cfg_offset;
   logic [9:0] cfg_gain;
   int send_idle_pct;
   int recv_stall_pct;
   int mismatch_count = 0;
   tilt_result_type expected_tilts [$];

   accel_tilt_angle #(.CORDIC_STEPS(TILT_STEPS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_x_low(req_x_low),
      .req_x_high(req_x_high),
      .req_y_low(req_y_low),
      .req_y_high(req_y_high),
      .req_z_low(req_z_low),
      .req_z_high(req_z_high),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accel_x(rsp_accel_x),
      .rsp_accel_y(rsp_accel_y),
      .rsp_accel_z(rsp_accel_z),
      .rsp_vec_first(rsp_vec_first),
      .rsp_vec_second(rsp_vec_second),
      .rsp_vec_third(rsp_vec_third),
      .rsp_tilt_angle(rsp_tilt_angle),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("accel_tilt_angle_tb NOT OK");
      $finish;
   end

   // readings, remapped vector and corrected, scaled tilt for one sample
   function automatic tilt_result_type predict_tilt(input raw_sample_type s);
      tilt_result_type r;
      longint ax, ay, az, x, y, z, t, dx, dy, a, neg_x, neg_z;
      ax = longint'($signed({s.xh, s.xl}));
      ay = longint'($signed({s.yh, s.yl}));
      az = longint'($signed({s.zh, s.zl}));
      x = az * 256;
      y = ax * 256;
      z = 0;
      if (ax == 0 && az == 0) begin
         a = 0;
      end else begin
         // left half plane: turn a quarter toward +x first
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = RIGHT_ANGLE;
            end else begin
               t = x; x = -y; y = t; z = -RIGHT_ANGLE;
            end
         end
         for (int i = 0; i < TILT_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += ATAN_STEP[i];
            end else begin
               x -= dx; y += dy; z -= ATAN_STEP[i];
            end
         end
         a = (z + 128) >>> 8;
         if (a > RAW_BOUND) a = RAW_BOUND;
         if (a < -RAW_BOUND) a = -RAW_BOUND;
      end
      if (a > 0) a -= longint'(cfg_offset);
      a = (a * longint'(cfg_gain) + 128) >>> 8;
      if (a > TILT_BOUND) a = TILT_BOUND;
      if (a < -TILT_BOUND) a = -TILT_BOUND;
      neg_x = -ax;
      neg_z = -az;
      r.ax = ax[15:0];
      r.ay = ay[15:0];
      r.az = az[15:0];
      r.vf = ay[15:0];
      r.vs = neg_x[16:0];
      r.vt = neg_z[16:0];
      r.tilt = a[17:0];
      return r;
   endfunction

   // mostly full-range readings, with zeros, tiny values and rails mixed in
   function automatic logic [15:0] pick_reading();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 60) return 16'($urandom);
      if (kind < 75) return 16'($urandom_range(0, 16)) - 16'd8;
      if (kind < 85) return 16'h0000;
      case ($urandom_range(0, 3))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0001;
         default: return 16'hffff;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_sample(input raw_sample_type s, input tilt_result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_x_low, req_x_high, req_y_low, req_y_high, req_z_low, req_z_high} <= s;
      do @(posedge clock); while (req_stall);
      expected_tilts.push_back(want);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_tilts.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == {ata_pkg::REG_ANGLE_OFFSET, 2'b00}) cfg_offset = data[15:0];
      else cfg_gain = data[9:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin : check_results
      tilt_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_accel_x, rsp_accel_y, rsp_accel_z, rsp_vec_first,
                 rsp_vec_second, rsp_vec_third, rsp_tilt_angle};
         if (expected_tilts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: x=%0d y=%0d z=%0d tilt=%0d",
                        got.ax, got.ay, got.az, got.tilt);
         end else begin
            want = expected_tilts.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: got x=%0d y=%0d z=%0d v=(%0d,%0d,%0d) tilt=%0d",
                           got.ax, got.ay, got.az, got.vf, got.vs, got.vt, got.tilt);
                  $display("          exp x=%0d y=%0d z=%0d v=(%0d,%0d,%0d) tilt=%0d",
                           want.ax, want.ay, want.az, want.vf, want.vs, want.vt,
                           want.tilt);
               end
            end
         end
      end
   end

   initial begin
      raw_sample_type s;
      logic [15:0] rx, ry, rz, new_offset;
      logic [9:0] new_gain;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_x_low, req_x_high, req_y_low, req_y_high, req_z_low, req_z_high} = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_offset = 16'd2324;
      cfg_gain = 10'd384;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // probe table at the reset settings
      foreach (PROBES[i]) begin
         s = '{PROBES[i].x[7:0], PROBES[i].x[15:8], PROBES[i].y[7:0], PROBES[i].y[15:8],
               PROBES[i].z[7:0], PROBES[i].z[15:8]};
         send_sample(s, PROBES[i].typed ? PROBES[i].want : predict_tilt(s));
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         if (phase > 0) begin
            case (phase)
               1: begin new_offset = 16'd0;     new_gain = 10'd0;    end
               2: begin new_offset = 16'hffff;  new_gain = 10'd1023; end
               3: begin new_offset = 16'd46080; new_gain = 10'd256;  end
               4: begin new_offset = 16'd0;     new_gain = 10'd1023; end
               6: begin new_offset = 16'd1;     new_gain = 10'd1;    end
               default: begin
                  new_offset = 16'($urandom_range(0, 65535));
                  new_gain = 10'($urandom_range(0, 1023));
               end
            endcase
            // settings change only with the pipeline empty
            drain_results();
            write_reg({ata_pkg::REG_ANGLE_OFFSET, 2'b00}, {16'h0000, new_offset});
            write_reg({ata_pkg::REG_ANGLE_GAIN, 2'b00}, {22'h0, new_gain});
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            rx = pick_reading();
            ry = 16'($urandom);
            rz = pick_reading();
            s = '{rx[7:0], rx[15:8], ry[7:0], ry[15:8], rz[7:0], rz[15:8]};
            send_sample(s, predict_tilt(s));
         end
      end

      drain_results();
      repeat (PIPE_DRAIN) @(posedge clock);
      if (mismatch_count == 0 && expected_tilts.size() == 0) begin
         $display("accel_tilt_angle_tb OK");
      end else begin
         $display("accel_tilt_angle_tb NOT OK");
      end
      $finish;
   end

endmodule
